/* sv/cci_pkg.sv */
// Shared types and constants for the circle collision impulse resolver.
package cci_pkg;

	// Configuration register layout and reset values.
	localparam int CFG_W = 17;
	localparam logic [CFG_W-1:0] PCT_RESET  = 17'd52429;
	localparam logic [CFG_W-1:0] SLOP_RESET = 17'd655;
	localparam logic REG_PCT  = 1'b0;
	localparam logic REG_SLOP = 1'b1;

	// Iterative unit sizing.
	localparam int QW           = 36;
	localparam int U_DEN_W      = 33;
	localparam int U_SH_W       = 66;
	localparam int U_CNT_W      = 7;
	localparam int SQRT_STEPS   = 33;
	localparam int MULDIV_STEPS = 36;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [30:0]        mass;
		logic [30:0]        radius;
		logic [16:0]        restitution;
	} item_t;

	typedef struct packed {
		logic               body_select;
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic               touched;
		logic               last_result;
	} result_t;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		DP_NONE,
		DP_DIFF,
		DP_SQX,
		DP_SQY,
		DP_SQRT,
		DP_CHK,
		DP_NX,
		DP_NY,
		DP_DOTX,
		DP_DOTY,
		DP_PEN,
		DP_SHARE,
		DP_DB,
		DP_DO,
		DP_UMUL,
		DP_UADD,
		DP_KK
	} dp_op_t;

	typedef struct packed {
		logic   accept;
		dp_op_t op;
		logic [2:0] idx;
		logic   out_sel;
	} cmd_t;

	typedef struct packed {
		logic held_valid;
		logic unit_done;
		logic contact;
		logic deep;
		logic approach;
	} status_t;

endpackage

/* sv/cci_divsqrt.sv */
// Shared iterative unit: restoring division or digit-by-digit square root.
module cci_divsqrt
	import cci_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               run,
	input  logic               sqrt_mode,
	input  logic [32:0]        rem_init,
	input  logic [U_SH_W-1:0]  sh_init,
	input  logic [U_CNT_W-1:0] steps,
	input  logic [U_DEN_W-1:0] den,
	output logic               done,
	output logic [QW-1:0]      quo
);

	logic               active_q;
	logic [U_CNT_W-1:0] cnt_q;
	logic               mode_q;
	logic [34:0]        rem_q;
	logic [U_SH_W-1:0]  sh_q;
	logic [QW-1:0]      quo_q;
	logic [U_DEN_W-1:0] den_q;

	logic [33:0] div_t;
	logic        div_ge;
	logic [33:0] div_r;
	logic [36:0] sq_t;
	logic [34:0] sq_trial;
	logic        sq_ge;
	logic [36:0] sq_r;

	// One quotient bit per step: shift in the next dividend bit and try the divisor.
	assign div_t  = {rem_q[32:0], sh_q[U_SH_W-1]};
	assign div_ge = div_t >= {1'b0, den_q};
	assign div_r  = div_t - {1'b0, den_q};

	// One root bit per step: bring down two radicand bits and try 4*root+1.
	assign sq_t     = {rem_q, sh_q[U_SH_W-1 -: 2]};
	assign sq_trial = {quo_q[32:0], 2'b01};
	assign sq_ge    = sq_t >= {2'b00, sq_trial};
	assign sq_r     = sq_t - {2'b00, sq_trial};

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (!active_q) begin
			if (run) begin
				active_q <= 1'b1;
				cnt_q    <= steps;
			end
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end else begin
			active_q <= 1'b0;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (!active_q) begin
			if (run) begin
				mode_q <= sqrt_mode;
				rem_q  <= {2'b00, rem_init};
				sh_q   <= sh_init;
				quo_q  <= '0;
				den_q  <= den;
			end
		end else if (cnt_q != '0) begin
			if (mode_q) begin
				rem_q <= sq_ge ? sq_r[34:0] : sq_t[34:0];
				quo_q <= {quo_q[QW-2:0], sq_ge};
				sh_q  <= {sh_q[U_SH_W-3:0], 2'b00};
			end else begin
				rem_q <= {2'b00, div_ge ? div_r[32:0] : div_t[32:0]};
				quo_q <= {quo_q[QW-2:0], div_ge};
				sh_q  <= {sh_q[U_SH_W-2:0], 1'b0};
			end
		end
	end

	assign done = active_q && (cnt_q == '0);
	assign quo  = quo_q;

endmodule

/* sv/cci_datapath.sv */
// Datapath: held body, working registers, multipliers and the iterative unit.
module cci_datapath
	import cci_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            item,
	input  logic [CFG_W-1:0] pct,
	input  logic [CFG_W-1:0] slop,
	input  cmd_t             cmd,
	output status_t          status,
	output result_t          result
);

	localparam int NW   = FRAC_BITS + 1;
	localparam int SNW  = FRAC_BITS + 2;
	localparam int DOTW = FRAC_BITS + 35;
	localparam int SW   = FRAC_BITS + 36;
	localparam int KPW  = SW + 18;
	localparam int IPW  = QW + NW;
	localparam int PMW  = QW + 31;

	// Held body.
	logic signed [31:0] hpx_q, hpy_q, hvx_q, hvy_q;
	logic [30:0]        hm_q, hr_q;
	logic [16:0]        he_q;
	logic               hvalid_q;

	// Incoming body.
	logic signed [31:0] opx_q, opy_q, ovx_q, ovy_q;
	logic [30:0]        om_q, or_q;
	logic [16:0]        oe_q;

	// Contact geometry and impulse terms.
	logic [32:0]            adx_q, ady_q;
	logic                   nxneg_q, nyneg_q;
	logic signed [32:0]     rvx_q, rvy_q;
	logic [30:0]            bm_q, omf_q;
	logic [31:0]            tm_q, rs_q;
	logic [65:0]            sqx_q, sqy_q;
	logic [32:0]            d_q;
	logic [NW-1:0]          anx_q, any_q;
	logic signed [DOTW-1:0] dotx_q, doty_q;
	logic signed [SW-1:0]   s_q;
	logic                   deep_q;
	logic [31:0]            x_q;
	logic [QW-1:0]          share_q, qb_q, qo_q, inc_q;
	logic                   touched_q;

	logic signed [32:0] dx, dy, dvx, dvy;
	logic [30:0]        bm_c, om_c;
	logic               u_run, u_sqrt, u_done;
	logic [32:0]        u_rem;
	logic [U_SH_W-1:0]  u_sh;
	logic [U_CNT_W-1:0] u_steps;
	logic [U_DEN_W-1:0] u_den;
	logic [QW-1:0]      u_quo;
	logic [PMW-1:0]     prod_m;
	logic signed [SNW-1:0]  snx, sny;
	logic signed [DOTW-1:0] dot_p;
	logic [31:0]        pen;
	logic [48:0]        share_p;
	logic [16:0]        e_min;
	logic [17:0]        e_fac;
	logic [SW-1:0]      negs;
	logic [KPW-1:0]     kk_p;
	logic [IPW-1:0]     inc_p;
	logic               neg_c, sub_c;
	logic signed [31:0] base_c, upd_c;
	logic signed [37:0] sum_c;

	// Differences, magnitudes and mass terms for the contact.
	assign dx   = {opx_q[31], opx_q} - {hpx_q[31], hpx_q};
	assign dy   = {opy_q[31], opy_q} - {hpy_q[31], hpy_q};
	assign dvx  = {ovx_q[31], ovx_q} - {hvx_q[31], hvx_q};
	assign dvy  = {ovy_q[31], ovy_q} - {hvy_q[31], hvy_q};
	assign bm_c = (hm_q != '0) ? hm_q : 31'd1;
	assign om_c = (om_q != '0) ? om_q : 31'd1;

	// Operands for the iterative unit, chosen by the running operation.
	assign prod_m = PMW'(share_q) * PMW'((cmd.op == DP_DO) ? bm_q : omf_q);

	always_comb begin
		u_run   = 1'b0;
		u_sqrt  = 1'b0;
		u_rem   = '0;
		u_sh    = '0;
		u_steps = '0;
		u_den   = '0;
		case (cmd.op)
			DP_SQRT: begin
				u_run   = 1'b1;
				u_sqrt  = 1'b1;
				u_sh    = sqx_q + sqy_q;
				u_steps = U_CNT_W'(SQRT_STEPS);
			end
			DP_NX: begin
				u_run   = 1'b1;
				u_rem   = {1'b0, adx_q[32:1]};
				u_sh    = {adx_q[0], {(U_SH_W-1){1'b0}}};
				u_steps = U_CNT_W'(NW);
				u_den   = d_q;
			end
			DP_NY: begin
				u_run   = 1'b1;
				u_rem   = {1'b0, ady_q[32:1]};
				u_sh    = {ady_q[0], {(U_SH_W-1){1'b0}}};
				u_steps = U_CNT_W'(NW);
				u_den   = d_q;
			end
			DP_DB, DP_DO: begin
				u_run   = 1'b1;
				u_rem   = {2'b00, prod_m[QW+30:QW]};
				u_sh    = {prod_m[QW-1:0], {(U_SH_W-QW){1'b0}}};
				u_steps = U_CNT_W'(MULDIV_STEPS);
				u_den   = {1'b0, tm_q};
			end
			default: begin
				u_run = 1'b0;
			end
		endcase
	end

	cci_divsqrt u_divsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.run       (u_run),
		.sqrt_mode (u_sqrt),
		.rem_init  (u_rem),
		.sh_init   (u_sh),
		.steps     (u_steps),
		.den       (u_den),
		.done      (u_done),
		.quo       (u_quo)
	);

	// Signed normal components and the dot product term.
	assign snx   = nxneg_q ? -$signed({1'b0, anx_q}) : $signed({1'b0, anx_q});
	assign sny   = nyneg_q ? -$signed({1'b0, any_q}) : $signed({1'b0, any_q});
	assign dot_p = (cmd.op == DP_DOTY) ? DOTW'(rvy_q) * DOTW'(sny)
	                                   : DOTW'(rvx_q) * DOTW'(snx);

	// Penetration, correction share and impulse magnitude.
	assign pen     = rs_q - d_q[31:0];
	assign share_p = 49'(x_q) * 49'(pct);
	assign e_min   = (he_q < oe_q) ? he_q : oe_q;
	assign e_fac   = {1'b0, e_min} + 18'd65536;
	assign negs    = $unsigned(-s_q);
	assign kk_p    = KPW'(negs) * KPW'(e_fac);

	// Per-coordinate increment: share times normal component.
	assign inc_p = IPW'(cmd.idx[1] ? qo_q : qb_q) * IPW'(cmd.idx[0] ? any_q : anx_q);

	// Nudge of one coordinate, saturated to 32 bits. The increment stays below 2^36.
	assign neg_c = cmd.idx[0] ? nyneg_q : nxneg_q;
	assign sub_c = cmd.idx[1] ? neg_c : !neg_c;

	always_comb begin
		case (cmd.idx)
			3'd0:    base_c = hpx_q;
			3'd1:    base_c = hpy_q;
			3'd2:    base_c = opx_q;
			3'd3:    base_c = opy_q;
			3'd4:    base_c = hvx_q;
			3'd5:    base_c = hvy_q;
			3'd6:    base_c = ovx_q;
			default: base_c = ovy_q;
		endcase
	end

	assign sum_c = sub_c ? (38'(base_c) - $signed({2'b00, inc_q}))
	                     : (38'(base_c) + $signed({2'b00, inc_q}));

	always_comb begin
		if (sum_c > 38'sd2147483647) begin
			upd_c = 32'sh7FFFFFFF;
		end else if (sum_c < -38'sd2147483648) begin
			upd_c = 32'sh80000000;
		end else begin
			upd_c = sum_c[31:0];
		end
	end

	// Held body valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= 1'b0;
		end else if (cmd.accept && !item.kind) begin
			hvalid_q <= 1'b1;
		end
	end

	// Payload registers, written under the controller's operation code.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (!item.kind) begin
				hpx_q <= item.pos_x;
				hpy_q <= item.pos_y;
				hvx_q <= item.vel_x;
				hvy_q <= item.vel_y;
				hm_q  <= item.mass;
				hr_q  <= item.radius;
				he_q  <= item.restitution;
			end
			opx_q <= item.pos_x;
			opy_q <= item.pos_y;
			ovx_q <= item.vel_x;
			ovy_q <= item.vel_y;
			om_q  <= item.mass;
			or_q  <= item.radius;
			oe_q  <= item.restitution;
		end
		if (u_done) begin
			case (cmd.op)
				DP_SQRT: d_q   <= u_quo[32:0];
				DP_NX:   anx_q <= u_quo[NW-1:0];
				DP_NY:   any_q <= u_quo[NW-1:0];
				DP_DB:   qb_q  <= u_quo;
				DP_DO:   qo_q  <= u_quo;
				default: d_q   <= d_q;
			endcase
		end
		case (cmd.op)
			DP_DIFF: begin
				adx_q   <= dx[32] ? 33'(-dx) : 33'(dx);
				ady_q   <= dy[32] ? 33'(-dy) : 33'(dy);
				nxneg_q <= dx[32];
				nyneg_q <= dy[32];
				rvx_q   <= dvx;
				rvy_q   <= dvy;
				bm_q    <= bm_c;
				omf_q   <= om_c;
				tm_q    <= {1'b0, bm_c} + {1'b0, om_c};
				rs_q    <= {1'b0, hr_q} + {1'b0, or_q};
			end
			DP_SQX: sqx_q <= 66'(adx_q) * 66'(adx_q);
			DP_SQY: sqy_q <= 66'(ady_q) * 66'(ady_q);
			DP_CHK: touched_q <= status.contact;
			DP_DOTX: dotx_q <= dot_p;
			DP_DOTY: doty_q <= dot_p;
			DP_PEN: begin
				s_q    <= SW'(dotx_q) + SW'(doty_q);
				deep_q <= pen > {15'd0, slop};
				x_q    <= pen - {15'd0, slop};
			end
			DP_SHARE: share_q <= QW'(share_p >> 16);
			DP_KK:    share_q <= QW'(kk_p >> (16 + FRAC_BITS));
			DP_UMUL:  inc_q   <= QW'(inc_p >> FRAC_BITS);
			DP_UADD: begin
				case (cmd.idx)
					3'd0:    hpx_q <= upd_c;
					3'd1:    hpy_q <= upd_c;
					3'd2:    opx_q <= upd_c;
					3'd3:    opy_q <= upd_c;
					3'd4:    hvx_q <= upd_c;
					3'd5:    hvy_q <= upd_c;
					3'd6:    ovx_q <= upd_c;
					default: ovy_q <= upd_c;
				endcase
			end
			default: begin
				inc_q <= inc_q;
			end
		endcase
	end

	// Status back to the controller.
	assign status.held_valid = hvalid_q;
	assign status.unit_done  = u_done;
	assign status.contact    = (d_q != '0) && (d_q < {1'b0, rs_q});
	assign status.deep       = deep_q;
	assign status.approach   = s_q[SW-1] || (s_q == '0);

	// Result: held body first, incoming body second.
	assign result.body_select = cmd.out_sel;
	assign result.new_pos_x   = cmd.out_sel ? opx_q : hpx_q;
	assign result.new_pos_y   = cmd.out_sel ? opy_q : hpy_q;
	assign result.new_vel_x   = cmd.out_sel ? ovx_q : hvx_q;
	assign result.new_vel_y   = cmd.out_sel ? ovy_q : hvy_q;
	assign result.touched     = touched_q;
	assign result.last_result = cmd.out_sel;

endmodule

/* sv/cci_ctrl.sv */
// Controller state machine that sequences one resolve transaction.
module cci_ctrl
	import cci_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_kind,
	input  logic    result_stall,
	input  status_t status,
	output cmd_t    cmd,
	output logic    item_stall,
	output logic    result_valid
);

	typedef enum logic [19:0] {
		ST_IDLE   = 20'h00001,
		ST_DIFF   = 20'h00002,
		ST_SQX    = 20'h00004,
		ST_SQY    = 20'h00008,
		ST_SQRT   = 20'h00010,
		ST_CHK    = 20'h00020,
		ST_NX     = 20'h00040,
		ST_NY     = 20'h00080,
		ST_DOTX   = 20'h00100,
		ST_DOTY   = 20'h00200,
		ST_PEN    = 20'h00400,
		ST_SHARE  = 20'h00800,
		ST_DIVB   = 20'h01000,
		ST_DIVO   = 20'h02000,
		ST_UMUL   = 20'h04000,
		ST_UADD   = 20'h08000,
		ST_IMPCHK = 20'h10000,
		ST_KK     = 20'h20000,
		ST_EMIT0  = 20'h40000,
		ST_EMIT1  = 20'h80000
	} state_t;

	state_t     state_q;
	logic [2:0] idx_q;
	logic       accept;
	dp_op_t     op_c;

	assign accept = item_valid && (state_q == ST_IDLE);

	// Sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && item_kind && status.held_valid) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SQRT;
				ST_SQRT: begin
					if (status.unit_done) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: state_q <= status.contact ? ST_NX : ST_EMIT0;
				ST_NX: begin
					if (status.unit_done) begin
						state_q <= ST_NY;
					end
				end
				ST_NY: begin
					if (status.unit_done) begin
						state_q <= ST_DOTX;
					end
				end
				ST_DOTX: state_q <= ST_DOTY;
				ST_DOTY: state_q <= ST_PEN;
				ST_PEN:  state_q <= ST_SHARE;
				ST_SHARE: begin
					idx_q   <= 3'd0;
					state_q <= status.deep ? ST_DIVB : ST_IMPCHK;
				end
				ST_DIVB: begin
					if (status.unit_done) begin
						state_q <= ST_DIVO;
					end
				end
				ST_DIVO: begin
					if (status.unit_done) begin
						state_q <= ST_UMUL;
					end
				end
				ST_UMUL: state_q <= ST_UADD;
				ST_UADD: begin
					idx_q <= idx_q + 3'd1;
					if (idx_q[1:0] == 2'b11) begin
						state_q <= idx_q[2] ? ST_EMIT0 : ST_IMPCHK;
					end else begin
						state_q <= ST_UMUL;
					end
				end
				ST_IMPCHK: begin
					idx_q   <= 3'd4;
					state_q <= status.approach ? ST_KK : ST_EMIT0;
				end
				ST_KK: state_q <= ST_DIVB;
				ST_EMIT0: begin
					if (!result_stall) begin
						state_q <= ST_EMIT1;
					end
				end
				ST_EMIT1: begin
					if (!result_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath operation for each state.
	always_comb begin
		case (state_q)
			ST_DIFF:  op_c = DP_DIFF;
			ST_SQX:   op_c = DP_SQX;
			ST_SQY:   op_c = DP_SQY;
			ST_SQRT:  op_c = DP_SQRT;
			ST_CHK:   op_c = DP_CHK;
			ST_NX:    op_c = DP_NX;
			ST_NY:    op_c = DP_NY;
			ST_DOTX:  op_c = DP_DOTX;
			ST_DOTY:  op_c = DP_DOTY;
			ST_PEN:   op_c = DP_PEN;
			ST_SHARE: op_c = DP_SHARE;
			ST_DIVB:  op_c = DP_DB;
			ST_DIVO:  op_c = DP_DO;
			ST_UMUL:  op_c = DP_UMUL;
			ST_UADD:  op_c = DP_UADD;
			ST_KK:    op_c = DP_KK;
			default:  op_c = DP_NONE;
		endcase
	end

	assign cmd.accept    = accept;
	assign cmd.op        = op_c;
	assign cmd.idx       = idx_q;
	assign cmd.out_sel   = (state_q == ST_EMIT1);
	assign item_stall    = (state_q != ST_IDLE);
	assign result_valid  = (state_q == ST_EMIT0) || (state_q == ST_EMIT1);

endmodule

/* sv/circle_collision_impulse_resolver.sv */
// Top level: configuration registers, controller and datapath of the contact resolver.
//
// A load transaction (kind 0) stores the held body on acceptance and gives no result.
// A resolve transaction (kind 1) runs on a single shared iterative unit that computes
// the floor square root of the squared distance, the two normal components and up to
// four mass-weighted divisions, with one multiplier step per product. Without contact
// a resolve goes from the contact check straight to the results; position correction
// and impulse are each skipped when not needed, and any output stall lengthens it. One
// transaction is worked on at a time; the next is accepted after both results are taken.
module circle_collision_impulse_resolver
	import cci_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [CFG_W-1:0] pct_q, slop_q;
	cmd_t             cmd;
	status_t          status;

	// Configuration registers, written in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q  <= PCT_RESET;
			slop_q <= SLOP_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_PCT:  pct_q  <= pwdata[CFG_W-1:0];
				REG_SLOP: slop_q <= pwdata[CFG_W-1:0];
				default:  pct_q  <= pct_q;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SLOP) ? {15'd0, slop_q} : {15'd0, pct_q};

	cci_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_kind    (item.kind),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd),
		.item_stall   (item_stall),
		.result_valid (result_valid)
	);

	cci_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.pct    (pct_q),
		.slop   (slop_q),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

	// No new transaction is taken while a result is pending.
	a_stall_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("input accepted while a result is pending");

	// The held-body result is always followed by the incoming-body result.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && !result.last_result)
		|=> (result_valid && result.last_result))
		else $error("second result of the pair missing");

	// A load transaction leaves the block idle in the next cycle, with no result.
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && !item.kind) |=> (!item_stall && !result_valid))
		else $error("load transaction did not return to idle");

endmodule

/* tb/circle_collision_impulse_resolver_test.sv */
// Testbench for the circle collision impulse resolver: random contacts checked against a predictor.
module circle_collision_impulse_resolver_test;
	import cci_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam longint unsigned CAP = 64'd1 << 40;
	localparam logic [2:0] ADDR_PCT  = 3'd0;
	localparam logic [2:0] ADDR_SLOP = 3'd4;

	// Contact predictor: holds its own copy of the held body and the registers.
	class contact_scoreboard;
		logic [16:0] pct;
		logic [16:0] slop;
		longint hx, hy, hvx, hvy;
		longint unsigned hm, hr, he;
		bit hvalid;
		result_t pending[$];
		int errors;

		function void clear();
			pct = PCT_RESET;
			slop = SLOP_RESET;
			hx = 0; hy = 0; hvx = 0; hvy = 0;
			hm = 0; hr = 0; he = 0;
			hvalid = 0;
			errors = 0;
			pending.delete();
		endfunction

		// floor(a*b/c) with saturation to all ones.
		function longint unsigned scale(longint unsigned a, longint unsigned b,
			longint unsigned c);
			logic [127:0] p;
			logic [127:0] q;
			if (c == 0) return '1;
			p = 128'(a) * 128'(b);
			q = p / 128'(c);
			if (q[127:64] != 0) return '1;
			return q[63:0];
		endfunction

		function longint shift_pos(longint base, bit sub, longint unsigned mag);
			longint m;
			longint v;
			m = (mag > CAP) ? longint'(CAP) : longint'(mag);
			v = sub ? base - m : base + m;
			if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
			if (v < -64'sh80000000) v = -64'sh80000000;
			return v;
		endfunction

		function void note_item(item_t it);
			longint ox, oy, ovx, ovy, bx, by, bvx, bvy, dx, dy, snx, sny, s;
			longint unsigned om, bm, tm, adx, ady, d, rs, anx, any, pen, share;
			longint unsigned sb, so, kk, kb, ko, e;
			logic [127:0] sq;
			logic [127:0] r;
			logic [127:0] c;
			bit touch, nxn, nyn;
			result_t res;
			ox = longint'(it.pos_x); oy = longint'(it.pos_y);
			ovx = longint'(it.vel_x); ovy = longint'(it.vel_y);
			om = it.mass;
			if (it.kind == 1'b0) begin
				hx = ox; hy = oy; hvx = ovx; hvy = ovy;
				hm = om; hr = it.radius; he = it.restitution;
				hvalid = 1;
				return;
			end
			if (!hvalid) return;
			bx = hx; by = hy; bvx = hvx; bvy = hvy;
			bm = (hm != 0) ? hm : 1;
			if (om == 0) om = 1;
			tm = bm + om;
			dx = ox - bx; dy = oy - by;
			nxn = dx < 0; nyn = dy < 0;
			adx = nxn ? -dx : dx; ady = nyn ? -dy : dy;
			sq = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
			r = 0;
			for (int b = 33; b >= 0; b--) begin
				c = r | (128'd1 << b);
				if (c * c <= sq) r = c;
			end
			d = r[63:0];
			rs = hr + it.radius;
			touch = 0;
			if (d != 0 && d < rs) begin
				touch = 1;
				pen = rs - d;
				anx = (adx << FRAC) / d;
				any = (ady << FRAC) / d;
				snx = nxn ? -longint'(anx) : longint'(anx);
				sny = nyn ? -longint'(any) : longint'(any);
				s = (ovx - bvx) * snx + (ovy - bvy) * sny;
				if (pen > slop) begin
					share = scale(pen - slop, pct, 65536);
					sb = scale(share, om, tm);
					so = scale(share, bm, tm);
					bx = shift_pos(bx, !nxn, scale(sb, anx, 64'd1 << FRAC));
					by = shift_pos(by, !nyn, scale(sb, any, 64'd1 << FRAC));
					ox = shift_pos(ox, nxn, scale(so, anx, 64'd1 << FRAC));
					oy = shift_pos(oy, nyn, scale(so, any, 64'd1 << FRAC));
				end
				if (s <= 0) begin
					e = (he < it.restitution) ? he : it.restitution;
					kk = scale(-s, 65536 + e, 64'd1 << (16 + FRAC));
					kb = scale(kk, om, tm);
					ko = scale(kk, bm, tm);
					bvx = shift_pos(bvx, !nxn, scale(kb, anx, 64'd1 << FRAC));
					bvy = shift_pos(bvy, !nyn, scale(kb, any, 64'd1 << FRAC));
					ovx = shift_pos(ovx, nxn, scale(ko, anx, 64'd1 << FRAC));
					ovy = shift_pos(ovy, nyn, scale(ko, any, 64'd1 << FRAC));
				end
				hx = bx; hy = by; hvx = bvx; hvy = bvy;
			end
			res = '{1'b0, bx[31:0], by[31:0], bvx[31:0], bvy[31:0], touch, 1'b0};
			pending.push_back(res);
			res = '{1'b1, ox[31:0], oy[31:0], ovx[31:0], ovy[31:0], touch, 1'b1};
			pending.push_back(res);
		endfunction

		task report(string what, longint got, longint want);
			$display("error: %s got %h expected %h", what, got, want);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				report("unexpected result", got.new_pos_x, 0);
				return;
			end
			want = pending.pop_front();
			if (got.body_select !== want.body_select)
				report("body_select", got.body_select, want.body_select);
			if (got.new_pos_x !== want.new_pos_x) report("new_pos_x", got.new_pos_x, want.new_pos_x);
			if (got.new_pos_y !== want.new_pos_y) report("new_pos_y", got.new_pos_y, want.new_pos_y);
			if (got.new_vel_x !== want.new_vel_x) report("new_vel_x", got.new_vel_x, want.new_vel_x);
			if (got.new_vel_y !== want.new_vel_y) report("new_vel_y", got.new_vel_y, want.new_vel_y);
			if (got.touched !== want.touched) report("touched", got.touched, want.touched);
			if (got.last_result !== want.last_result)
				report("last_result", got.last_result, want.last_result);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 0;
	result_t result;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	contact_scoreboard board;
	int hold_cycles = 0;
	bit stall_random = 1;

	circle_collision_impulse_resolver #(.FRAC_BITS(FRAC)) u_dut (.*);

	always #5 clk = ~clk;

	// Sample accepted transactions at the rising edge.
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) board.note_item(item);
		if (arst_n && result_valid && !result_stall) board.check_result(result);
	end

	// Receiver stall pattern, with an occasional long hold-off.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			result_stall <= 1;
		end else if (stall_random) begin
			result_stall <= ($urandom_range(0, 3) == 0);
		end else begin
			result_stall <= 0;
		end
	end

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// Offer one item and hold it until accepted.
	task automatic send_item(item_t it);
		item <= it;
		item_valid <= 1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		item_valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	// Wait until every expected result arrived, plus the block's tail latency.
	task automatic drain();
		item_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	function automatic item_t rand_body(bit kind, bit near);
		item_t it;
		it.kind = kind;
		if (near) begin
			it.pos_x = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
			it.pos_y = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
			it.vel_x = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
			it.vel_y = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
			it.mass = 31'($urandom_range(1, 100 << 16));
			it.radius = 31'($urandom_range(0, 12 << 16));
			it.restitution = 17'($urandom_range(0, 65536));
		end else begin
			it.pos_x = $urandom; it.pos_y = $urandom;
			it.vel_x = $urandom; it.vel_y = $urandom;
			it.mass = 31'($urandom); it.radius = 31'($urandom);
			it.restitution = 17'($urandom);
		end
		return it;
	endfunction

	task automatic directed();
		item_t it;
		// Resolve before any load gives nothing.
		send_item(rand_body(1, 1));
		// Coincident centers: no contact.
		it = '{1'b0, 0, 0, 0, 0, 31'd65536, 31'd65536, 17'd65536};
		send_item(it);
		it.kind = 1; send_item(it);
		// Deep head-on contact, approaching.
		it = '{1'b0, 0, 0, 32'sd65536, 0, 31'd65536, 31'd65536, 17'd65536};
		send_item(it);
		it = '{1'b1, 32'sd65536, 0, -32'sd65536, 0, 31'd0, 31'd65536, 17'd0};
		send_item(it);
		// Separating, shallow contact.
		it = '{1'b0, 0, 0, -32'sd65536, 0, 31'd0, 31'd65536, 17'd131071};
		send_item(it);
		it = '{1'b1, 32'sd131000, -32'sd100, 32'sd65536, 0, 31'd1, 31'd65536, 17'd131071};
		send_item(it);
		// Field extremes.
		it = '{1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			31'h7FFFFFFF, 31'h7FFFFFFF, 17'h1FFFF};
		send_item(it);
		it = '{1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			31'h7FFFFFFF, 31'h7FFFFFFF, 17'h1FFFF};
		send_item(it);
		it.kind = 1; it.pos_x = 32'h7FFFFFF0; it.pos_y = 32'h80000010;
		send_item(it);
		it = '{1'b1, 0, 0, 0, 0, 31'd0, 31'd0, 17'd0};
		send_item(it);
		repeat (8) send_item(rand_body(1, 1));
		drain();
	endtask

	// One random phase of n items.
	task automatic random_phase(int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			int burst;
			burst = $urandom_range(1, 8);
			for (int i = 0; i < burst && sent < n; i++) begin
				send_item(rand_body($urandom_range(0, 3) == 0, $urandom_range(0, 9) != 0));
				sent++;
			end
			if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
			if ($urandom_range(0, 40) == 0) begin
				item_valid <= 0;
				while (board.pending.size() != 0) @(negedge clk);
			end
		end
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		directed();
		random_phase(250);
		drain();
		write_reg(ADDR_PCT, 32'd65536);
		write_reg(ADDR_SLOP, 32'd0);
		board.pct = 17'd65536; board.slop = 17'd0;
		// Long receiver hold-off while items keep coming.
		hold_cycles = 800;
		random_phase(250);
		drain();
		write_reg(ADDR_PCT, 32'd0);
		write_reg(ADDR_SLOP, 32'd65536);
		board.pct = 17'd0; board.slop = 17'd65536;
		stall_random = 0;
		random_phase(150);
		stall_random = 1;
		drain();
		write_reg(ADDR_PCT, 32'd131071);
		write_reg(ADDR_SLOP, 32'd1);
		board.pct = 17'h1FFFF; board.slop = 17'd1;
		random_phase(150);
		drain();
		write_reg(ADDR_PCT, 32'd52429);
		write_reg(ADDR_SLOP, 32'd655);
		board.pct = 17'd52429; board.slop = 17'd655;
		random_phase(330);
		drain();
		if (board.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
